// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRDF_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRDF_ASSERT(lbl, prop, msg)
`define CRDF_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/crdf_pkg.sv
package crdf_pkg;

    // Datapath widths.
    localparam int XW = 44;   // dividend: raw count times circumference
    localparam int DW = 46;   // divisor: up to raw count times ten thousand
    localparam int QW = 25;   // quotient bits, one per divider stage
    localparam int VW = 25;   // displayed value
    localparam int TW = DW + QW;
    localparam int WW = 52;   // threshold products for speed ranges

    localparam logic [11:0] CIRC_RESET = 12'd2136;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_DIST    = 3'd0,
        OP_TIME    = 3'd1,
        OP_SPEED   = 3'd2,
        OP_CADENCE = 3'd3,
        OP_WHEEL   = 3'd4
    } crdf_op_t;

    // Side information that travels with each item through the divider.
    typedef struct packed {
        logic [2:0]    op;
        logic [1:0]    point;
        logic          force_zero;
        logic          bypass;
        logic [VW-1:0] bypass_value;
    } crdf_meta_t;

    localparam logic [7:0] POINT_BIT = 8'h80;

    // Seven-segment code of one decimal digit; anything above nine is blank.
    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] code;
        case (d)
            4'd0: code = 8'h3f;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5b;
            4'd3: code = 8'h4f;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6d;
            4'd6: code = 8'h7d;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7f;
            4'd9: code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Glyph shown in the top byte for each mode.
    function automatic logic [7:0] mode_glyph(input logic [2:0] op);
        logic [7:0] code;
        case (op)
            OP_DIST:    code = 8'h5e;
            OP_TIME:    code = 8'h78;
            OP_SPEED:   code = 8'h0c;
            OP_CADENCE: code = 8'h58;
            OP_WHEEL:   code = 8'h39;
            default:    code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/crdf_div.sv
module crdf_div
    import crdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [XW-1:0]    x,
    input  logic [DW-1:0]    d,
    input  crdf_meta_t       meta_in,
    output logic             out_vld,
    output logic [QW-1:0]    quo,
    output crdf_meta_t       meta_out
);

    // One restoring step per stage, most significant quotient bit first.
    logic [XW-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];
    logic [QW-1:0] quo_reg  [0:QW-1];
    crdf_meta_t    meta_reg [0:QW-1];
    logic [QW-1:0] vld_reg;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [XW-1:0] src_rem;
        logic [DW-1:0] src_den;
        logic [QW-1:0] src_quo;
        crdf_meta_t    src_meta;
        logic          src_vld;
        logic [TW-1:0] trial;
        logic [TW-1:0] rem_ext;
        logic          ge;

        if (i == 0) begin : g_first
            assign src_rem  = x;
            assign src_den  = d;
            assign src_quo  = '0;
            assign src_meta = meta_in;
            assign src_vld  = in_vld;
        end else begin : g_next
            assign src_rem  = rem_reg[i-1];
            assign src_den  = den_reg[i-1];
            assign src_quo  = quo_reg[i-1];
            assign src_meta = meta_reg[i-1];
            assign src_vld  = vld_reg[i-1];
        end

        // Compare the partial remainder with the divisor at this bit weight.
        assign trial   = TW'(src_den) << (QW - 1 - i);
        assign rem_ext = TW'(src_rem);
        assign ge      = (rem_ext >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? XW'(rem_ext - trial) : src_rem;
                den_reg[i]  <= src_den;
                quo_reg[i]  <= {src_quo[QW-2:0], ge};
                meta_reg[i] <= src_meta;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quo      = quo_reg[QW-1];
    assign meta_out = meta_reg[QW-1];

endmodule

// File: rtl/cycle_reading_display_formatter.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_data (wheel circumference, mm)
// in       | in_valid / in_ready    | op, raw_count
// out      | out_valid / out_ready  | led_word, reading_value, point_position
//
// One transaction is accepted per cycle while the output is not stalled; each
// passes through two setup stages, 25 stages of the pipelined divider (one quotient
// bit each), four formatting stages and the output register.
// The whole pipeline advances together; it holds while the output register is
// full and not taken, so in_ready follows out_ready.
// Reset clears all valid bits and loads the circumference with 2136 mm.
`include "assert_macros.svh"
module cycle_reading_display_formatter
    import crdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [31:0] raw_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] led_word,
    output logic [24:0] reading_value,
    output logic [1:0]  point_position
);

    logic en;
    logic [11:0] circ_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg <= CIRC_RESET;
        end
        else if (cfg_valid)
        begin
            circ_reg <= cfg_data;
        end
    end

    // The pipeline moves whenever the output register can take a new item.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage A: products of the raw count.
    logic          vld_a_reg;
    logic [2:0]    op_a_reg;
    logic [31:0]   raw_a_reg;
    logic [XW-1:0] dist_a_reg;
    logic [32:0]   n_a_reg;
    logic [DW-1:0] raw100_a_reg;
    logic [DW-1:0] raw1k_a_reg;
    logic [DW-1:0] raw10k_a_reg;
    logic [WW-1:0] raw1e5_a_reg;
    logic [WW-1:0] raw1e6_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg     <= op;
            raw_a_reg    <= raw_count;
            dist_a_reg   <= XW'(raw_count) * XW'(circ_reg);
            n_a_reg      <= {16'(circ_reg) * 16'd9, 17'd0};
            raw100_a_reg <= DW'(raw_count) * DW'(100);
            raw1k_a_reg  <= DW'(raw_count) * DW'(1000);
            raw10k_a_reg <= DW'(raw_count) * DW'(10000);
            raw1e5_a_reg <= WW'(raw_count) * WW'(100000);
            raw1e6_a_reg <= WW'(raw_count) * WW'(1000000);
        end
    end

    // Stage B: range selection, dividend and divisor.
    logic          vld_b_reg;
    logic [XW-1:0] x_b_reg, x_b_next;
    logic [DW-1:0] d_b_reg, d_b_next;
    crdf_meta_t    meta_b_reg, meta_b_next;

    always_comb
    begin
        x_b_next                  = '0;
        d_b_next                  = DW'(1);
        meta_b_next.op            = op_a_reg;
        meta_b_next.point         = 2'd0;
        meta_b_next.force_zero    = 1'b0;
        meta_b_next.bypass        = 1'b0;
        meta_b_next.bypass_value  = raw_a_reg[VW-1:0];
        case (op_a_reg)
            OP_DIST:
            begin
                x_b_next = dist_a_reg;
                if (dist_a_reg <= XW'(10000000))
                begin
                    d_b_next          = DW'(10000);
                    meta_b_next.point = 2'd2;
                end
                else if (dist_a_reg <= XW'(100000000))
                begin
                    d_b_next          = DW'(100000);
                    meta_b_next.point = 2'd1;
                end
                else
                begin
                    d_b_next          = DW'(1000000);
                    meta_b_next.point = 2'd0;
                end
            end
            OP_TIME:
            begin
                // Whole minutes: ticks / 2^17 / 15.
                x_b_next = XW'(raw_a_reg[31:17]);
                d_b_next = DW'(15);
            end
            OP_SPEED:
            begin
                x_b_next = XW'(n_a_reg);
                if (raw_a_reg == '0)
                begin
                    meta_b_next.force_zero = 1'b1;
                    meta_b_next.point      = 2'd2;
                end
                else if (WW'(n_a_reg) <= raw1e5_a_reg)
                begin
                    d_b_next          = raw100_a_reg;
                    meta_b_next.point = 2'd2;
                end
                else if (WW'(n_a_reg) <= raw1e6_a_reg)
                begin
                    d_b_next          = raw1k_a_reg;
                    meta_b_next.point = 2'd1;
                end
                else
                begin
                    d_b_next          = raw10k_a_reg;
                    meta_b_next.point = 2'd0;
                end
            end
            OP_CADENCE:
            begin
                if (raw_a_reg == '0)
                begin
                    meta_b_next.force_zero = 1'b1;
                end
                else
                begin
                    x_b_next = XW'(1966080);
                    d_b_next = DW'(raw_a_reg);
                end
            end
            OP_WHEEL:
            begin
                meta_b_next.bypass = 1'b1;
            end
            default:
            begin
                meta_b_next.force_zero = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_b_reg    <= x_b_next;
            d_b_reg    <= d_b_next;
            meta_b_reg <= meta_b_next;
        end
    end

    // Pipelined divider.
    logic          vld_q;
    logic [QW-1:0] quo_q;
    crdf_meta_t    meta_q;

    crdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_b_reg),
        .x        (x_b_reg),
        .d        (d_b_reg),
        .meta_in  (meta_b_reg),
        .out_vld  (vld_q),
        .quo      (quo_q),
        .meta_out (meta_q)
    );

    // Stage C: minutes times 2185/2^17 gives whole hours.
    logic          vld_c_reg;
    logic [QW-1:0] quo_c_reg;
    crdf_meta_t    meta_c_reg;
    logic [22:0]   hmul_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_c_reg <= vld_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_c_reg  <= quo_q;
            meta_c_reg <= meta_q;
            hmul_c_reg <= 23'(quo_q[11:0]) * 23'd2185;
        end
    end

    // Stage D: final reading and point position.
    logic          vld_d_reg;
    logic [VW-1:0] value_d_reg, value_d_next;
    logic [1:0]    point_d_reg, point_d_next;
    logic [2:0]    op_d_reg;
    logic [6:0]    hours;
    logic [11:0]   mins_wide;
    logic [5:0]    mins;
    logic [13:0]   mins_x205;
    logic [2:0]    mins_tens;

    assign hours     = 7'(hmul_c_reg[22:17]);
    assign mins_wide = quo_c_reg[11:0] - 12'(hours) * 12'd60;
    assign mins      = mins_wide[5:0];
    assign mins_x205 = 14'(mins) * 14'd205;
    assign mins_tens = mins_x205[13:11];

    always_comb
    begin
        value_d_next = quo_c_reg;
        point_d_next = meta_c_reg.point;
        if (meta_c_reg.force_zero)
        begin
            value_d_next = '0;
        end
        else if (meta_c_reg.bypass)
        begin
            value_d_next = meta_c_reg.bypass_value;
        end
        else if (meta_c_reg.op == OP_TIME)
        begin
            if (hours >= 7'd10)
            begin
                value_d_next = VW'(hours) * VW'(10) + VW'(mins_tens);
                point_d_next = 2'd1;
            end
            else
            begin
                value_d_next = VW'(hours) * VW'(100) + VW'(mins);
                point_d_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_d_reg <= value_d_next;
            point_d_reg <= point_d_next;
            op_d_reg    <= meta_c_reg.op;
        end
    end

    // Stage E: value times ceil(2^32/100) for the hundreds split.
    logic          vld_e_reg;
    logic [VW-1:0] value_e_reg;
    logic [1:0]    point_e_reg;
    logic [2:0]    op_e_reg;
    logic [50:0]   prod_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_e_reg <= value_d_reg;
            point_e_reg <= point_d_reg;
            op_e_reg    <= op_d_reg;
            prod_e_reg  <= 51'(value_d_reg) * 51'd42949673;
        end
    end

    // Stage F: hundreds digit and the remainder below one hundred.
    logic          vld_f_reg;
    logic [VW-1:0] value_f_reg;
    logic [1:0]    point_f_reg;
    logic [2:0]    op_f_reg;
    logic [6:0]    rem_f_reg;
    logic [7:0]    hund_f_reg;
    logic [18:0]   q100;
    logic [VW-1:0] rem_wide;

    assign q100     = prod_e_reg[50:32];
    assign rem_wide = value_e_reg - VW'(q100) * VW'(100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_f_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_f_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_f_reg <= value_e_reg;
            point_f_reg <= point_e_reg;
            op_f_reg    <= op_e_reg;
            rem_f_reg   <= rem_wide[6:0];
            hund_f_reg  <= (q100 < 19'd10) ? digit_code(q100[3:0]) : 8'h00;
        end
    end

    // Output register: tens and ones digits, packed display word.
    logic        out_valid_reg;
    logic [31:0] led_word_reg, led_word_next;
    logic [24:0] value_reg;
    logic [1:0]  point_reg;
    logic [14:0] rem_x205;
    logic [3:0]  tens;
    logic [6:0]  ones_wide;
    logic [7:0]  tens_code;
    logic [7:0]  hund_code;

    assign rem_x205  = 15'(rem_f_reg) * 15'd205;
    assign tens      = rem_x205[14:11];
    assign ones_wide = rem_f_reg - 7'(tens) * 7'd10;

    always_comb
    begin
        tens_code = digit_code(tens);
        hund_code = hund_f_reg;
        if (point_f_reg == 2'd1)
        begin
            tens_code = tens_code | POINT_BIT;
        end
        else if (point_f_reg == 2'd2)
        begin
            hund_code = hund_code | POINT_BIT;
        end
        led_word_next = {mode_glyph(op_f_reg), hund_code, tens_code,
                         digit_code(ones_wide[3:0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            led_word_reg <= led_word_next;
            value_reg    <= value_f_reg;
            point_reg    <= point_f_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_word       = led_word_reg;
    assign reading_value  = value_reg;
    assign point_position = point_reg;

    // Checks.
    `CRDF_NEVER(a_point_range, out_valid_reg && (point_reg == 2'd3), "point position out of range")
    `CRDF_ASSERT(a_hund_shown, (out_valid_reg && (value_reg < 25'd1000) |-> (led_word_reg[22:16] != 7'd0)), "hundreds digit blank below 1000")
    `CRDF_ASSERT(a_accept_empty, (!out_valid_reg |-> in_ready), "input stalled with empty output")

endmodule

// File: sim/testbench.sv
module testbench;
    import crdf_pkg::*;

    // One expected reading, as it should appear on the output channel.
    typedef struct packed {
        logic [31:0] word;
        logic [24:0] value;
        logic [1:0]  point;
    } reading_t;

    // A directed stimulus row; typed rows carry their own expectation.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] raw;
        logic        typed;
        logic [31:0] word;
        logic [24:0] value;
        logic [1:0]  point;
    } dir_row_t;

    localparam int NUM_DIR = 25;
    localparam int SETTLE_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 600000;
    localparam longint unsigned TICKS_HOUR = 117964800;
    localparam longint unsigned TICKS_MINUTE = 1966080;
    localparam longint unsigned SPEED_FACTOR = 1179648;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [31:0] raw_count;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] led_word;
    logic [24:0] reading_value;
    logic [1:0]  point_position;

    reading_t    pending_readings[$];
    logic [11:0] circ_mm;
    int          fail_count;
    longint      cycle_count;
    logic        hold_request;
    logic        steady_ready;
    dir_row_t    dir_rows [0:NUM_DIR-1];

    cycle_reading_display_formatter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .raw_count      (raw_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .led_word       (led_word),
        .reading_value  (reading_value),
        .point_position (point_position)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Seven-segment code for one decimal digit; values above nine are blank.
    function automatic logic [7:0] seg_pattern(input longint unsigned d);
        case (d)
            0: return 8'h3f;
            1: return 8'h06;
            2: return 8'h5b;
            3: return 8'h4f;
            4: return 8'h66;
            5: return 8'h6d;
            6: return 8'h7d;
            7: return 8'h07;
            8: return 8'h7f;
            9: return 8'h6f;
            default: return 8'h00;
        endcase
    endfunction

    // Works out the formatted reading for one transaction.
    function automatic reading_t format_reading(input logic [2:0] mode,
                                                input logic [31:0] raw_in,
                                                input logic [11:0] circ);
        longint unsigned raw;
        longint unsigned c;
        longint unsigned prod;
        longint unsigned hours;
        longint unsigned mins;
        longint unsigned num;
        longint unsigned val;
        longint unsigned v;
        logic [1:0]      pnt;
        logic [7:0]      glyph;
        reading_t        r;
        raw = longint'(raw_in);
        c = longint'(circ);
        val = 0;
        pnt = 2'd0;
        glyph = 8'h00;
        case (mode)
            OP_DIST:
            begin
                glyph = 8'h5e;
                prod = raw * c;
                if (prod <= 64'd10000000)
                begin
                    val = prod / 10000;
                    pnt = 2'd2;
                end
                else if (prod <= 64'd100000000)
                begin
                    val = prod / 100000;
                    pnt = 2'd1;
                end
                else
                begin
                    val = prod / 1000000;
                end
            end
            OP_TIME:
            begin
                glyph = 8'h78;
                hours = raw / TICKS_HOUR;
                mins = (raw % TICKS_HOUR) / TICKS_MINUTE;
                if (hours >= 10)
                begin
                    val = hours * 10 + mins / 10;
                    pnt = 2'd1;
                end
                else
                begin
                    val = hours * 100 + mins;
                    pnt = 2'd2;
                end
            end
            OP_SPEED:
            begin
                glyph = 8'h0c;
                num = c * SPEED_FACTOR;
                if (raw == 0)
                begin
                    pnt = 2'd2;
                end
                else if (num <= 100000 * raw)
                begin
                    val = num / (100 * raw);
                    pnt = 2'd2;
                end
                else if (num <= 1000000 * raw)
                begin
                    val = num / (1000 * raw);
                    pnt = 2'd1;
                end
                else
                begin
                    val = num / (10000 * raw);
                end
            end
            OP_CADENCE:
            begin
                glyph = 8'h58;
                val = (raw == 0) ? 0 : TICKS_MINUTE / raw;
            end
            OP_WHEEL:
            begin
                glyph = 8'h39;
                val = raw;
            end
            default:
            begin
                val = 0;
            end
        endcase
        v = val & 64'h1FFFFFF;
        r.word = {glyph, seg_pattern(v / 100), seg_pattern((v % 100) / 10),
                  seg_pattern(v % 10)};
        if (pnt == 2'd1)
            r.word[15] = 1'b1;
        else if (pnt == 2'd2)
            r.word[23] = 1'b1;
        r.value = v[24:0];
        r.point = pnt;
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return $urandom_range(2);
        else if (pick < 95)
            return $urandom_range(10, 3);
        else
            return $urandom_range(60, 20);
    endfunction

    // Offers one transaction and waits until it is taken.
    task automatic send_reading(input logic [2:0] mode, input logic [31:0] raw_in,
                                input logic typed, input reading_t typed_exp);
        in_valid <= 1'b1;
        op <= mode;
        raw_count <= raw_in;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            pending_readings.push_back(typed_exp);
        else
            pending_readings.push_back(format_reading(mode, raw_in, circ_mm));
        @(negedge clk);
    endtask

    // Idle gap between transactions; a zero gap keeps valid high.
    task automatic idle_sender(input logic no_gaps);
        int gap;
        gap = no_gaps ? 0 : gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Writes the circumference once the pipeline has drained.
    task automatic write_circ(input logic [11:0] mm);
        in_valid <= 1'b0;
        wait (pending_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mm;
        do
            @(posedge clk);
        while (!cfg_ready);
        circ_mm = mm;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random raw count, biased toward the range boundaries of each mode.
    function automatic logic [31:0] pick_raw(input logic [2:0] mode, input logic [11:0] circ);
        int                 kind;
        longint unsigned    c;
        longint unsigned    base;
        kind = $urandom_range(3);
        c = longint'(circ);
        if (kind == 0)
            return $urandom();
        if (kind == 1)
            return $urandom_range(1000);
        if (kind == 2 && c != 0)
        begin
            case (mode)
                OP_DIST:
                    base = (($urandom_range(1) == 1) ? 64'd100000000 : 64'd10000000) / c;
                OP_TIME:
                    base = $urandom_range(36) * TICKS_HOUR + $urandom_range(59) * TICKS_MINUTE;
                OP_SPEED:
                    base = c * SPEED_FACTOR / (($urandom_range(1) == 1) ? 100000 : 1000000);
                default:
                    base = $urandom_range(100000);
            endcase
            return base[31:0] + 32'($urandom_range(2)) - 32'd1;
        end
        return $urandom() >> $urandom_range(31);
    endfunction

    // Random part of one phase: mostly valid modes, some undefined ones.
    task automatic random_phase(input int count, input logic with_hold);
        logic [2:0] mode;
        logic       no_gaps;
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == 10)
                hold_request = 1'b1;
            if (i % 40 == 0)
                no_gaps = ($urandom_range(3) == 0);
            steady_ready = no_gaps;
            mode = ($urandom_range(99) < 88) ? 3'($urandom_range(4))
                                             : 3'($urandom_range(7, 5));
            send_reading(mode, pick_raw(mode, circ_mm), 1'b0, '0);
            idle_sender(no_gaps);
        end
        steady_ready = 1'b0;
    endtask

    // Receiver handshake: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (steady_ready)
            begin
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < 25)
            begin
                stall_left = gap_cycles();
                out_ready <= (stall_left == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transaction with the oldest expected reading.
    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected output transaction: led_word %h", led_word);
                fail_count++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (led_word !== exp_r.word)
                begin
                    $error("led_word: expected %h, got %h", exp_r.word, led_word);
                    fail_count++;
                end
                if (reading_value !== exp_r.value)
                begin
                    $error("reading_value: expected %0d, got %0d", exp_r.value, reading_value);
                    fail_count++;
                end
                if (point_position !== exp_r.point)
                begin
                    $error("point_position: expected %0d, got %0d",
                           exp_r.point, point_position);
                    fail_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle_reading_display_formatter: mismatch");
            $finish;
        end
    end

    initial
    begin
        reading_t tx;
        logic     outcome_ok;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        raw_count = '0;
        circ_mm = CIRC_RESET;
        fail_count = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        steady_ready = 1'b0;

        dir_rows = '{
            '{3'(OP_WHEEL),   32'd0,          1'b1, 32'h393f3f3f, 25'd0,        2'd0},
            '{3'(OP_WHEEL),   32'hFFFFFFFF,   1'b1, 32'h39004f06, 25'd33554431, 2'd0},
            '{3'(OP_WHEEL),   32'd999,        1'b1, 32'h396f6f6f, 25'd999,      2'd0},
            '{3'd5,           32'd12345,      1'b1, 32'h003f3f3f, 25'd0,        2'd0},
            '{3'd6,           32'hFFFFFFFF,   1'b1, 32'h003f3f3f, 25'd0,        2'd0},
            '{3'd7,           32'd0,          1'b1, 32'h003f3f3f, 25'd0,        2'd0},
            '{3'(OP_CADENCE), 32'd0,          1'b1, 32'h583f3f3f, 25'd0,        2'd0},
            '{3'(OP_SPEED),   32'd0,          1'b1, 32'h0cbf3f3f, 25'd0,        2'd2},
            '{3'(OP_DIST),    32'd0,          1'b1, 32'h5ebf3f3f, 25'd0,        2'd2},
            '{3'(OP_TIME),    32'd0,          1'b1, 32'h78bf3f3f, 25'd0,        2'd2},
            '{3'(OP_DIST),    32'hFFFFFFFF,   1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_DIST),    32'd4681,       1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_DIST),    32'd4682,       1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_DIST),    32'd46816,      1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_TIME),    32'hFFFFFFFF,   1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_TIME),    32'd1179648000, 1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_TIME),    32'd1179647999, 1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_SPEED),   32'd1,          1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_SPEED),   32'hFFFFFFFF,   1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_SPEED),   32'd25198,      1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_SPEED),   32'd25197,      1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_SPEED),   32'd2519,       1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_CADENCE), 32'd1,          1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_CADENCE), 32'hFFFFFFFF,   1'b0, 32'h0,        25'd0,        2'd0},
            '{3'(OP_CADENCE), 32'd1966080,    1'b0, 32'h0,        25'd0,        2'd0}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at the reset circumference.
        for (int i = 0; i < NUM_DIR; i++)
        begin
            tx.word = dir_rows[i].word;
            tx.value = dir_rows[i].value;
            tx.point = dir_rows[i].point;
            send_reading(dir_rows[i].op, dir_rows[i].raw, dir_rows[i].typed, tx);
            idle_sender(1'b0);
        end

        // Random phases over several circumferences, extremes included.
        random_phase(100, 1'b1);
        write_circ(12'd0);
        random_phase(80, 1'b0);
        write_circ(12'd4095);
        random_phase(120, 1'b0);
        // Sender waits for the pipeline to empty before going on.
        wait (pending_readings.size() == 0);
        write_circ(12'd1);
        random_phase(80, 1'b0);
        write_circ(12'($urandom_range(4094, 2)));
        random_phase(120, 1'b1);
        write_circ(CIRC_RESET);
        random_phase(100, 1'b0);
        in_valid <= 1'b0;

        wait (pending_readings.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        outcome_ok = (fail_count == 0) && (pending_readings.size() == 0);
        if (outcome_ok)
            $display("cycle_reading_display_formatter: match");
        else
            $display("cycle_reading_display_formatter: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/crdf_pkg.sv
rtl/crdf_div.sv
rtl/cycle_reading_display_formatter.sv
sim/testbench.sv
